FILE: rtl/clv_pkg.sv
// Package for the Content-Length validator: character classes, parser
// states, result status codes and the width of the value accumulator.
// Used by content_length_validator and its checker; depends on nothing.
package clv_pkg;

  // Width of the value accumulator and of length_value and length_limit.
  localparam int ValueBits = 48;
  localparam int DigitBits = 4;
  localparam int ProdBits  = ValueBits + DigitBits;

  // Configuration port: one 64-bit register at byte address 0.
  localparam int CfgDataBits = 64;
  localparam int CfgAddrBits = 4;

  // Largest value the accumulator holds; a run that would exceed it saturates.
  localparam logic [ValueBits-1:0] ValueMax = {ValueBits{1'b1}};

  // Characters that the parser tells apart.
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [1:0] {
    CL_OTHER,
    CL_BLANK,
    CL_COMMA,
    CL_DIGIT
  } char_class_t;

  // Parser states.
  typedef enum logic [2:0] {
    PS_START = 3'd2,
    PS_SEP   = 3'd3,
    PS_RUN   = 3'd4,
    PS_BLANK = 3'd5,
    PS_COMMA = 3'd6
  } parse_state_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_LEN_REQ = 2'd2
  } status_t;

  // Class of one header character.
  function automatic char_class_t classify(input logic [7:0] ch);
    char_class_t cl;
    cl = CL_OTHER;
    if (ch == ChTab || ch == ChSpace) begin
      cl = CL_BLANK;
    end else if (ch == ChComma) begin
      cl = CL_COMMA;
    end else if (ch >= ChZero && ch <= ChNine) begin
      cl = CL_DIGIT;
    end
    return cl;
  endfunction

endpackage

FILE: rtl/content_length_validator.sv
// Content-Length header value validator: parses the value one character per
// item and reports status, value, overflow and limit check on the end item.
// Depends on clv_pkg.
//
//   channel | direction | payload                                   | handshake
//   in_     | input     | in_byte_req, in_end_req                   | in_valid / in_ready
//   out_    | output    | out_status, out_length_value,             | out_valid / out_ready
//           |           | out_too_large, out_within_limit           |
//   cfg     | APB       | length_limit at byte address 0 (64 bits)  | psel/penable, pready=1
//
// One item is taken per cycle while in_ready is high. An accepted item is held in
// the input register; the parse step between that register and the result register
// then updates the state, and an end item leaving it loads the result register.
// Character items never stall. An end item waits in the input register while
// the result register holds an untaken result; in_ready drops for that time.
// rst_n is synchronous and active low; length_limit resets to 1048576.
module content_length_validator (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_byte_req,
  input  logic                                in_end_req,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic [clv_pkg::ValueBits-1:0]       out_length_value,
  output logic                                out_too_large,
  output logic                                out_within_limit,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [clv_pkg::CfgAddrBits-1:0]     paddr,
  input  logic [clv_pkg::CfgDataBits-1:0]     pwdata,
  output logic [clv_pkg::CfgDataBits-1:0]     prdata,
  output logic                                pready
);

  localparam int VB = clv_pkg::ValueBits;

  // Input register
  logic                 in_vld_r;
  logic [7:0]           byte_r;
  logic                 end_r;

  // Parser state
  clv_pkg::parse_state_t state_r, state_nxt;
  logic                 rejected_r, rejected_nxt;
  logic                 have_first_r, have_first_nxt;
  logic [VB-1:0]        first_val_r, first_val_nxt;
  logic                 first_ovf_r, first_ovf_nxt;
  logic [VB-1:0]        run_val_r, run_val_nxt;
  logic                 run_ovf_r, run_ovf_nxt;

  // Result register
  logic                 out_vld_r;
  clv_pkg::status_t     status_r, status_nxt;
  logic [VB-1:0]        value_r, value_nxt;
  logic                 big_r, big_nxt;
  logic                 within_r, within_nxt;

  // Configuration register
  logic [VB-1:0]        limit_r;

  // Step control
  logic                 advance;
  logic                 char_step;
  clv_pkg::char_class_t cls;
  logic [clv_pkg::DigitBits-1:0] digit;
  logic                 do_start, do_add, do_finish, do_reject;
  logic [clv_pkg::ProdBits-1:0]  prod;
  logic                 mismatch;
  logic [VB-1:0]        eff_val;
  logic                 eff_ovf;

  // The held item moves on unless it is an end item blocked by a full result.
  assign advance   = in_vld_r && (!end_r || !out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign char_step = advance && !end_r && !rejected_r;

  assign cls   = clv_pkg::classify(byte_r);
  assign digit = byte_r[clv_pkg::DigitBits-1:0];

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      byte_r <= in_byte_req;
      end_r  <= in_end_req;
    end
  end

  // Parser next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      clv_pkg::PS_START, clv_pkg::PS_SEP: begin
        if (cls == clv_pkg::CL_BLANK || cls == clv_pkg::CL_COMMA) begin
          state_nxt = clv_pkg::PS_SEP;
        end else if (cls == clv_pkg::CL_DIGIT) begin
          state_nxt = clv_pkg::PS_RUN;
        end
      end
      clv_pkg::PS_RUN: begin
        if (cls == clv_pkg::CL_BLANK) begin
          state_nxt = clv_pkg::PS_BLANK;
        end else if (cls == clv_pkg::CL_COMMA) begin
          state_nxt = clv_pkg::PS_COMMA;
        end
      end
      clv_pkg::PS_BLANK: begin
        if (cls == clv_pkg::CL_COMMA) begin
          state_nxt = clv_pkg::PS_COMMA;
        end
      end
      clv_pkg::PS_COMMA: begin
        if (cls == clv_pkg::CL_DIGIT) begin
          state_nxt = clv_pkg::PS_RUN;
        end
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
  end

  // Parser actions for one character
  always_comb begin
    do_start  = 1'b0;
    do_add    = 1'b0;
    do_finish = 1'b0;
    do_reject = 1'b0;
    case (state_r)
      clv_pkg::PS_START, clv_pkg::PS_SEP, clv_pkg::PS_COMMA: begin
        do_start  = (cls == clv_pkg::CL_DIGIT);
        do_reject = (cls == clv_pkg::CL_OTHER);
      end
      clv_pkg::PS_RUN: begin
        do_add    = (cls == clv_pkg::CL_DIGIT);
        do_finish = (cls != clv_pkg::CL_DIGIT);
        do_reject = (cls == clv_pkg::CL_OTHER);
      end
      clv_pkg::PS_BLANK: begin
        do_reject = (cls == clv_pkg::CL_OTHER) || (cls == clv_pkg::CL_DIGIT);
      end
      default: begin
        do_reject = 1'b1;
      end
    endcase
  end

  // Run accumulator: value times ten plus the digit, saturating past ValueMax.
  assign prod = ({{clv_pkg::DigitBits{1'b0}}, run_val_r} << 3)
              + ({{clv_pkg::DigitBits{1'b0}}, run_val_r} << 1)
              + {{VB{1'b0}}, digit};

  // A finished run must match the first one, overflow flag included.
  assign mismatch = have_first_r && ((run_val_r != first_val_r) || (run_ovf_r != first_ovf_r));
  assign eff_val  = have_first_r ? first_val_r : run_val_r;
  assign eff_ovf  = have_first_r ? first_ovf_r : run_ovf_r;

  // Parser data path
  always_comb begin
    rejected_nxt   = rejected_r;
    have_first_nxt = have_first_r;
    first_val_nxt  = first_val_r;
    first_ovf_nxt  = first_ovf_r;
    run_val_nxt    = run_val_r;
    run_ovf_nxt    = run_ovf_r;
    if (do_start) begin
      run_val_nxt = {{(VB-clv_pkg::DigitBits){1'b0}}, digit};
      run_ovf_nxt = 1'b0;
    end
    if (do_add && !run_ovf_r) begin
      if (prod > {{clv_pkg::DigitBits{1'b0}}, clv_pkg::ValueMax}) begin
        run_val_nxt = clv_pkg::ValueMax;
        run_ovf_nxt = 1'b1;
      end else begin
        run_val_nxt = prod[VB-1:0];
      end
    end
    if (do_finish) begin
      if (!have_first_r) begin
        have_first_nxt = 1'b1;
        first_val_nxt  = run_val_r;
        first_ovf_nxt  = run_ovf_r;
      end else if (mismatch) begin
        rejected_nxt = 1'b1;
      end
    end
    if (do_reject) begin
      rejected_nxt = 1'b1;
    end
  end

  // Result of an end item
  always_comb begin
    status_nxt = clv_pkg::ST_BAD;
    value_nxt  = '0;
    big_nxt    = 1'b0;
    within_nxt = 1'b0;
    if (!rejected_r) begin
      if (state_r == clv_pkg::PS_START) begin
        status_nxt = clv_pkg::ST_LEN_REQ;
      end else if ((state_r == clv_pkg::PS_RUN && !mismatch) ||
                   state_r == clv_pkg::PS_BLANK || state_r == clv_pkg::PS_COMMA) begin
        status_nxt = clv_pkg::ST_OK;
        value_nxt  = eff_val;
        big_nxt    = eff_ovf;
        within_nxt = !eff_ovf && (eff_val <= limit_r);
      end
    end
  end

  // Parser registers; an end item returns them to the start values.
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && end_r)) begin
      state_r      <= clv_pkg::PS_START;
      rejected_r   <= 1'b0;
      have_first_r <= 1'b0;
      first_val_r  <= '0;
      first_ovf_r  <= 1'b0;
      run_val_r    <= '0;
      run_ovf_r    <= 1'b0;
    end else if (char_step) begin
      state_r      <= state_nxt;
      rejected_r   <= rejected_nxt;
      have_first_r <= have_first_nxt;
      first_val_r  <= first_val_nxt;
      first_ovf_r  <= first_ovf_nxt;
      run_val_r    <= run_val_nxt;
      run_ovf_r    <= run_ovf_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && end_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
    if (advance && end_r) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      big_r    <= big_nxt;
      within_r <= within_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = status_r;
  assign out_length_value = value_r;
  assign out_too_large    = big_r;
  assign out_within_limit = within_r;

  // Configuration register; byte addresses below 8 select length_limit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= VB'(1048576);
    end else if (psel && penable && pwrite && !paddr[clv_pkg::CfgAddrBits-1]) begin
      limit_r <= pwdata[VB-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[clv_pkg::CfgAddrBits-1] ? '0
                : {{(clv_pkg::CfgDataBits-VB){1'b0}}, limit_r};

endmodule

FILE: rtl/clv_checker.sv
// Port-level checker for content_length_validator, bound to the top level.
// Depends on clv_pkg.
module clv_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    out_status,
  input logic [clv_pkg::ValueBits-1:0] out_length_value,
  input logic                          out_too_large,
  input logic                          out_within_limit
);

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_length_value) && $stable(out_within_limit))
    else $error("result changed while stalled");

  // Only the three defined status codes are reported.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == clv_pkg::ST_OK || out_status == clv_pkg::ST_BAD ||
                   out_status == clv_pkg::ST_LEN_REQ))
    else $error("undefined status code");

  // A failed value carries no length and no flags.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != clv_pkg::ST_OK |->
      out_length_value == '0 && !out_too_large && !out_within_limit)
    else $error("failed result carries data");

  // Within limit needs an ok status and no overflow.
  a_within: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_within_limit |-> out_status == clv_pkg::ST_OK && !out_too_large)
    else $error("within_limit without a valid length");

  // An overflowed value is saturated.
  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_large |-> out_length_value == clv_pkg::ValueMax)
    else $error("too_large without saturated value");

endmodule

bind content_length_validator clv_checker u_clv_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_length_value (out_length_value),
  .out_too_large    (out_too_large),
  .out_within_limit (out_within_limit)
);
